FILE: hw/rtl/rlpc_pkg.sv
package rlpc_pkg;

   // configuration register indexes
   localparam int REG_IDX_W = 1;
   localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

   localparam int CFG_DATA_W  = 16;
   localparam int WIDTH_REG_W = 11;
   localparam int ROW_W       = 16;
   localparam int OUT_COL_W   = 10;
   localparam int IN_VALUE_W  = 32;
   localparam int OUT_VALUE_W = 32;

   // request kinds
   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_DRAIN = 1'b1;

   // what the back end has to do with one queued item
   typedef struct packed {
      logic decide;
      logic wr_pending;
      logic from_input;
      logic has_up;
      logic has_right;
      logic has_down;
      logic last;
   } item_ctl_type;

   localparam int CTL_W = $bits(item_ctl_type);

endpackage

FILE: hw/rtl/rlpc_ram.sv
module rlpc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/rlpc_queue.sv
module rlpc_queue #(
   parameter int DATA_W = 64,
   parameter int DEPTH  = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  logic [DATA_W-1:0] push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [DATA_W-1:0] pop_data
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hw/rtl/rlpc_front.sv
module rlpc_front #(
   parameter int MAX_WIDTH  = 1024,
   parameter int PIXEL_BITS = 32,
   parameter int COL_W      = 10
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_type,
   input  logic [rlpc_pkg::IN_VALUE_W-1:0]    req_pixel_value,
   input  logic                               csr_we,
   input  logic [rlpc_pkg::REG_IDX_W-1:0]     csr_addr,
   input  logic [rlpc_pkg::CFG_DATA_W-1:0]    csr_wdata,
   output logic                               push_valid,
   input  logic                               push_ready,
   output rlpc_pkg::item_ctl_type             push_ctl,
   output logic [rlpc_pkg::ROW_W-1:0]         push_row,
   output logic [COL_W-1:0]                   push_col,
   output logic [PIXEL_BITS-1:0]              push_value
);
   logic [rlpc_pkg::WIDTH_REG_W-1:0] width_ff, width_in;
   logic [rlpc_pkg::ROW_W-1:0]       height_ff, height_in;
   logic [rlpc_pkg::ROW_W-1:0]       in_row_ff, in_row_in;
   logic [COL_W-1:0]                 in_col_ff, in_col_in;
   logic [COL_W-1:0]                 drain_col_ff, drain_col_in;
   logic                             draining_ff, draining_in;

   logic [15:0] w_raw, eff_w, eff_h;
   logic [15:0] in_c16, in_next16, dr_c16, dr_next16;
   logic [16:0] row_next17;
   logic        in_wrap, dr_wrap, row_wrap, accept;

   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      w_raw = 16'(width_ff);
      if (w_raw == 16'd0) begin
         eff_w = 16'd1;
      end else if (w_raw > 16'(MAX_WIDTH)) begin
         eff_w = 16'(MAX_WIDTH);
      end else begin
         eff_w = w_raw;
      end
      eff_h = (height_ff == '0) ? 16'd1 : height_ff;

      // column counters clamp to the last column in use
      in_c16 = 16'(in_col_ff);
      if (in_c16 >= eff_w) begin
         in_c16 = eff_w - 16'd1;
      end
      dr_c16 = 16'(drain_col_ff);
      if (dr_c16 >= eff_w) begin
         dr_c16 = eff_w - 16'd1;
      end
      in_next16  = in_c16 + 16'd1;
      dr_next16  = dr_c16 + 16'd1;
      in_wrap    = (in_next16 >= eff_w);
      dr_wrap    = (dr_next16 >= eff_w);
      row_next17 = {1'b0, in_row_ff} + 17'd1;
      row_wrap   = (row_next17 >= {1'b0, eff_h});
   end

   always_comb begin
      width_in     = width_ff;
      height_in    = height_ff;
      in_row_in    = in_row_ff;
      in_col_in    = in_col_ff;
      drain_col_in = drain_col_ff;
      draining_in  = draining_ff;
      push_valid   = 1'b0;
      push_ctl     = '0;
      push_row     = '0;
      push_col     = '0;
      push_value   = req_pixel_value[PIXEL_BITS-1:0];

      if (csr_we) begin
         case (csr_addr)
            rlpc_pkg::REG_FRAME_WIDTH: begin
               width_in = csr_wdata[rlpc_pkg::WIDTH_REG_W-1:0];
            end
            rlpc_pkg::REG_FRAME_HEIGHT: begin
               height_in = csr_wdata;
            end
            default: begin
            end
         endcase
         // any register write restarts the frame
         in_row_in    = '0;
         in_col_in    = '0;
         drain_col_in = '0;
         draining_in  = 1'b0;
      end else if (accept) begin
         case (req_type)
            rlpc_pkg::REQ_PIXEL: begin
               if (!draining_ff) begin
                  push_valid           = 1'b1;
                  push_ctl.decide      = (in_row_ff != '0);
                  push_ctl.wr_pending  = 1'b1;
                  push_ctl.from_input  = 1'b1;
                  push_ctl.has_up      = (in_row_ff >= 16'd2);
                  push_ctl.has_right   = !in_wrap;
                  push_ctl.has_down    = 1'b1;
                  push_ctl.last        = 1'b0;
                  push_row             = in_row_ff - 16'd1;
                  push_col             = in_c16[COL_W-1:0];
                  if (in_wrap) begin
                     in_col_in = '0;
                     if (row_wrap) begin
                        in_row_in    = '0;
                        drain_col_in = '0;
                        draining_in  = 1'b1;
                     end else begin
                        in_row_in = row_next17[15:0];
                     end
                  end else begin
                     in_col_in = in_next16[COL_W-1:0];
                  end
               end
            end
            rlpc_pkg::REQ_DRAIN: begin
               if (draining_ff) begin
                  push_valid           = 1'b1;
                  push_ctl.decide      = 1'b1;
                  push_ctl.wr_pending  = 1'b0;
                  push_ctl.from_input  = 1'b0;
                  push_ctl.has_up      = (eff_h >= 16'd2);
                  push_ctl.has_right   = !dr_wrap;
                  push_ctl.has_down    = 1'b0;
                  push_ctl.last        = dr_wrap;
                  push_row             = eff_h - 16'd1;
                  push_col             = dr_c16[COL_W-1:0];
                  if (dr_wrap) begin
                     in_row_in    = '0;
                     in_col_in    = '0;
                     drain_col_in = '0;
                     draining_in  = 1'b0;
                  end else begin
                     drain_col_in = dr_next16[COL_W-1:0];
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= rlpc_pkg::WIDTH_REG_W'(1024);
         height_ff    <= 16'd1;
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         drain_col_ff <= '0;
         draining_ff  <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         in_row_ff    <= in_row_in;
         in_col_ff    <= in_col_in;
         drain_col_ff <= drain_col_in;
         draining_ff  <= draining_in;
      end
   end

endmodule

FILE: hw/rtl/rlpc_back.sv
module rlpc_back #(
   parameter int MAX_WIDTH  = 1024,
   parameter int PIXEL_BITS = 32,
   parameter int COL_W      = 10
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               pop_valid,
   output logic                               pop_ready,
   input  rlpc_pkg::item_ctl_type             pop_ctl,
   input  logic [rlpc_pkg::ROW_W-1:0]         pop_row,
   input  logic [COL_W-1:0]                   pop_col,
   input  logic [PIXEL_BITS-1:0]              pop_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [rlpc_pkg::OUT_VALUE_W-1:0]   rsp_out_value,
   output logic [rlpc_pkg::ROW_W-1:0]         rsp_out_row,
   output logic [rlpc_pkg::OUT_COL_W-1:0]     rsp_out_col,
   output logic                               rsp_frame_last
);
   logic                          b_valid_ff, b_valid_in;
   rlpc_pkg::item_ctl_type        b_ctl_ff, b_ctl_in;
   logic [rlpc_pkg::ROW_W-1:0]    b_row_ff, b_row_in;
   logic [COL_W-1:0]              b_col_ff, b_col_in;
   logic [PIXEL_BITS-1:0]         b_value_ff, b_value_in;

   logic                          byp_up_ff, byp_up_in;
   logic [PIXEL_BITS-1:0]         byp_up_data_ff, byp_up_data_in;
   logic                          byp_pend_ff, byp_pend_in;
   logic [PIXEL_BITS-1:0]         byp_pend_data_ff, byp_pend_data_in;

   logic [PIXEL_BITS-1:0]         left_ff, left_in;
   logic [PIXEL_BITS-1:0]         right_ff, right_in;
   logic [PIXEL_BITS-1:0]         first_ff, first_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_BITS-1:0]         rsp_value_ff, rsp_value_in;
   logic [rlpc_pkg::ROW_W-1:0]    rsp_row_ff, rsp_row_in;
   logic [COL_W-1:0]              rsp_col_ff, rsp_col_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic [PIXEL_BITS-1:0]         up_rd, pend_rd, up_val, right_val, cur;
   logic [PIXEL_BITS-1:0]         m_up, m_left, m_right, m_down, t_a, t_b, top, res;
   logic                          has_left, peak, b_fire, b_take;
   logic                          up_we, pend_we;
   logic [COL_W-1:0]              pend_ra;
   logic [COL_W+rlpc_pkg::OUT_COL_W-1:0] col_ext;

   rlpc_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_upper_ram (
      .clock   (clock),
      .wr_en   (up_we),
      .wr_addr (b_col_ff),
      .wr_data (res),
      .rd_en   (b_take),
      .rd_addr (pop_col),
      .rd_data (up_rd)
   );

   rlpc_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_pending_ram (
      .clock   (clock),
      .wr_en   (pend_we),
      .wr_addr (b_col_ff),
      .wr_data (b_value_ff),
      .rd_en   (b_take),
      .rd_addr (pend_ra),
      .rd_data (pend_rd)
   );

   assign pend_ra = pop_col + COL_W'(1);

   always_comb begin
      up_val    = byp_up_ff ? byp_up_data_ff : up_rd;
      right_val = byp_pend_ff ? byp_pend_data_ff : pend_rd;
      has_left  = (b_col_ff != '0);
      // pixel being decided: column 0 kept aside, others came in as last right neighbor
      cur       = has_left ? right_ff : first_ff;

      peak = (!b_ctl_ff.has_up    || (cur > up_val))    &&
             (!has_left           || (cur > left_ff))   &&
             (!b_ctl_ff.has_right || (cur > right_val)) &&
             (!b_ctl_ff.has_down  || (cur > b_value_ff));

      m_up    = b_ctl_ff.has_up    ? up_val     : '0;
      m_left  = has_left           ? left_ff    : '0;
      m_right = b_ctl_ff.has_right ? right_val  : '0;
      m_down  = b_ctl_ff.has_down  ? b_value_ff : '0;
      t_a     = (m_up > m_left)  ? m_up    : m_left;
      t_b     = (m_right > m_down) ? m_right : m_down;
      top     = (t_a > t_b) ? t_a : t_b;
      res     = peak ? top : cur;
   end

   assign b_fire    = b_valid_ff && (!b_ctl_ff.decide || !rsp_valid_ff || rsp_ready);
   assign pop_ready = !b_valid_ff || b_fire;
   assign b_take    = pop_valid && pop_ready;
   assign up_we     = b_fire && b_ctl_ff.decide;
   assign pend_we   = b_fire && b_ctl_ff.wr_pending;

   always_comb begin
      b_valid_in       = b_valid_ff;
      b_ctl_in         = b_ctl_ff;
      b_row_in         = b_row_ff;
      b_col_in         = b_col_ff;
      b_value_in       = b_value_ff;
      byp_up_in        = byp_up_ff;
      byp_up_data_in   = byp_up_data_ff;
      byp_pend_in      = byp_pend_ff;
      byp_pend_data_in = byp_pend_data_ff;
      left_in          = left_ff;
      right_in         = right_ff;
      first_in         = first_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_value_in     = rsp_value_ff;
      rsp_row_in       = rsp_row_ff;
      rsp_col_in       = rsp_col_ff;
      rsp_last_in      = rsp_last_ff;

      if (b_take) begin
         b_valid_in = 1'b1;
         b_ctl_in   = pop_ctl;
         b_row_in   = pop_row;
         b_col_in   = pop_col;
         b_value_in = pop_value;
         // write landing in the same cycle as the read: ram gives old data
         byp_up_in        = up_we && (b_col_ff == pop_col);
         byp_up_data_in   = res;
         byp_pend_in      = pend_we && (b_col_ff == pend_ra);
         byp_pend_data_in = b_value_ff;
      end else if (b_fire) begin
         b_valid_in = 1'b0;
      end

      if (b_fire && b_ctl_ff.decide) begin
         left_in  = res;
         right_in = right_val;
      end
      if (b_fire && b_ctl_ff.from_input && !has_left) begin
         first_in = b_value_ff;
      end

      if (b_fire && b_ctl_ff.decide) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = res;
         rsp_row_in   = b_row_ff;
         rsp_col_in   = b_col_ff;
         rsp_last_in  = b_ctl_ff.last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b_ctl_ff         <= b_ctl_in;
      b_row_ff         <= b_row_in;
      b_col_ff         <= b_col_in;
      b_value_ff       <= b_value_in;
      byp_up_ff        <= byp_up_in;
      byp_up_data_ff   <= byp_up_data_in;
      byp_pend_ff      <= byp_pend_in;
      byp_pend_data_ff <= byp_pend_data_in;
      left_ff          <= left_in;
      right_ff         <= right_in;
      first_ff         <= first_in;
      rsp_value_ff     <= rsp_value_in;
      rsp_row_ff       <= rsp_row_in;
      rsp_col_ff       <= rsp_col_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign col_ext        = {{rlpc_pkg::OUT_COL_W{1'b0}}, rsp_col_ff};
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_value  = rlpc_pkg::OUT_VALUE_W'(rsp_value_ff);
   assign rsp_out_row    = rsp_row_ff;
   assign rsp_out_col    = col_ext[rlpc_pkg::OUT_COL_W-1:0];
   assign rsp_frame_last = rsp_last_ff;

endmodule

FILE: hw/rtl/raster_local_peak_clip.sv
// raster_local_peak_clip: clips local peaks of a raster frame in place.
// req channel: one item per pixel in raster order (req_type pixel), then,
// after the last row, one drain item per column (req_type drain). Pixel items
// while draining and drain items while not draining are taken and dropped.
// rsp channel: one item per decided pixel with its row, column and a
// frame_last flag on the frame's final pixel. Rows are decided one row late,
// so the first row of a frame gives no items and the drains give the last row.
// csr port: frame_width and frame_height, to be written only while idle by the
// user (the block does not enforce this); any write restarts the frame.
// Throughput: one item per cycle on both sides while rsp_ready stays high. A
// result passes the queue between the counter front end and the decision
// back end, then the back-end item register, loaded with the registered reads
// of the two row stores, then the result register. Store writes that hit the
// address read in the same cycle are forwarded.
// Reset: width 1024, height 1, counters cleared; row stores hold no defined
// contents and need no clearing, as a frame only reads what it wrote.
// A stalled rsp_ready holds the result register; the queue keeps taking items
// until it fills, then req_ready drops.
module raster_local_peak_clip #(
   parameter int MAX_WIDTH  = 1024,
   parameter int PIXEL_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_type,
   input  logic [rlpc_pkg::IN_VALUE_W-1:0]  req_pixel_value,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [rlpc_pkg::OUT_VALUE_W-1:0] rsp_out_value,
   output logic [rlpc_pkg::ROW_W-1:0]       rsp_out_row,
   output logic [rlpc_pkg::OUT_COL_W-1:0]   rsp_out_col,
   output logic                             rsp_frame_last,
   input  logic                             csr_we,
   input  logic [rlpc_pkg::REG_IDX_W-1:0]   csr_addr,
   input  logic [rlpc_pkg::CFG_DATA_W-1:0]  csr_wdata
);
   localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int Q_DEPTH = 4;
   localparam int Q_W     = rlpc_pkg::CTL_W + rlpc_pkg::ROW_W + COL_W + PIXEL_BITS;

   rlpc_pkg::item_ctl_type       push_ctl, pop_ctl;
   logic [rlpc_pkg::ROW_W-1:0]   push_row, pop_row;
   logic [COL_W-1:0]             push_col, pop_col;
   logic [PIXEL_BITS-1:0]        push_value, pop_value;
   logic                         push_valid, push_ready, pop_valid, pop_ready;
   logic [Q_W-1:0]               push_data, pop_data;

   rlpc_front #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS), .COL_W(COL_W)) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_pixel_value (req_pixel_value),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_ctl        (push_ctl),
      .push_row        (push_row),
      .push_col        (push_col),
      .push_value      (push_value)
   );

   assign push_data = {push_ctl, push_row, push_col, push_value};

   rlpc_queue #(.DATA_W(Q_W), .DEPTH(Q_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   assign pop_ctl   = rlpc_pkg::item_ctl_type'(pop_data[Q_W-1 -: rlpc_pkg::CTL_W]);
   assign pop_row   = pop_data[PIXEL_BITS+COL_W +: rlpc_pkg::ROW_W];
   assign pop_col   = pop_data[PIXEL_BITS +: COL_W];
   assign pop_value = pop_data[PIXEL_BITS-1:0];

   rlpc_back #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS), .COL_W(COL_W)) u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_ctl        (pop_ctl),
      .pop_row        (pop_row),
      .pop_col        (pop_col),
      .pop_value      (pop_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_value  (rsp_out_value),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule
